// File: rtl/core/mrss_pkg.sv
// mrss_pkg: types, widths and helpers shared by the rank scan statistic block.
// No dependencies.
package mrss_pkg;

	localparam int MAX_SITES    = 4096;
	localparam int MAX_VARS     = 16;
	localparam int MAX_CLUSTERS = 32;

	localparam int SUM_W   = 40;   // Q28.12 sums
	localparam int CNT_W   = 13;   // site counts
	localparam int VAR_W   = 4;    // variable index
	localparam int CL_W    = 5;    // cluster index
	localparam int ADDR_W  = CL_W + VAR_W;
	localparam int DEPTH   = MAX_CLUSTERS * MAX_VARS;
	localparam int MAG_W   = 36;   // magnitude of one sum
	localparam int WIDE_W  = 128;  // numerator / product width
	localparam int DEN_W   = 96;
	localparam int STAT_W  = 48;
	localparam int Q_W     = STAT_W + 1;
	localparam int MUL_STEPS = MAG_W;
	localparam int NVNS_W  = 17;

	localparam logic [CNT_W-1:0] SITE_LIMIT = CNT_W'(MAX_SITES);

	// configuration register indexes
	localparam logic CFG_VARS = 1'b0;
	localparam logic CFG_CLUS = 1'b1;

	typedef struct packed {
		logic signed [23:0] rank_value;
		logic [31:0]        member_mask;
		logic               final_item;
	} in_word_t;

	typedef struct packed {
		logic [4:0]        cluster_index;
		logic [STAT_W-1:0] statistic;
		logic              degenerate;
		logic              last_result;
	} out_word_t;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] x;
		logic [MAG_W-1:0]  y;
		logic [WIDE_W-1:0] init;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	function automatic logic [4:0] nv_eff(input logic [4:0] v);
		logic [4:0] r;
		if (v == 5'd0)
			r = 5'd1;
		else if (v > 5'(MAX_VARS))
			r = 5'(MAX_VARS);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [5:0] nc_eff(input logic [5:0] c);
		logic [5:0] r;
		if (c == 6'd0)
			r = 6'd1;
		else if (c > 6'(MAX_CLUSTERS))
			r = 6'(MAX_CLUSTERS);
		else
			r = c;
		return r;
	endfunction

endpackage

// File: rtl/core/mrss_sum_mem.sv
// mrss_sum_mem: inside-sum store, one cluster/variable entry per word.
// Uses mrss_pkg. One write port, one registered read port.
module mrss_sum_mem
	import mrss_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [SUM_W-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [SUM_W-1:0]  rdata
);

	logic [SUM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/mrss_mul.sv
// mrss_mul: shift-add multiplier, one multiplier bit per cycle, init + x*y.
// Uses mrss_pkg.
module mrss_mul
	import mrss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              done,
	output logic [WIDE_W-1:0] prod
);

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] x_q;
	logic [MAG_W-1:0]  y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.init;
			x_q   <= req.x;
			y_q   <= req.y;
		end else if (busy_q) begin
			if (y_q[0])
				acc_q <= acc_q + x_q;
			x_q <= {x_q[WIDE_W-2:0], 1'b0};
			y_q <= {1'b0, y_q[MAG_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: rtl/core/mrss_div.sv
// mrss_div: restoring divider, one quotient bit per cycle, saturated to 48 bits.
// Uses mrss_pkg.
module mrss_div
	import mrss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [STAT_W-1:0] quot
);

	localparam int D_W = DEN_W + STAT_W;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [WIDE_W-1:0] rem_q;
	logic [D_W-1:0]    d_q;
	logic [Q_W-1:0]    q_q;
	logic              ge;

	assign ge = {{(D_W-WIDE_W){1'b0}}, rem_q} >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			d_q   <= {req.den, {STAT_W{1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - d_q[WIDE_W-1:0];
			q_q <= {q_q[Q_W-2:0], ge};
			d_q <= {1'b0, d_q[D_W-1:1]};
		end
	end

	assign done = done_q;
	assign quot = q_q[Q_W-1] ? {STAT_W{1'b1}} : q_q[STAT_W-1:0];

endmodule

// File: rtl/core/multivariate_rank_scan_statistic.sv
// multivariate_rank_scan_statistic: rank scan statistic, accumulate and evaluate.
// Uses mrss_pkg, mrss_sum_mem, mrss_mul, mrss_div.
// Each word is accumulated in a walk of the sum memory, then the block returns to idle; ready only in idle.
// A final word then runs, per cluster, a pass on the shared multiplier and divider (skipped if
// degenerate) plus output stalls, then a clear of the whole sum memory.
// Reset: async active low; after reset a memory clear runs before ready.
module multivariate_rank_scan_statistic
	import mrss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [5:0] cfg_data
);

	typedef enum logic [15:0] {
		ST_CLEAR  = 16'h0001,
		ST_IDLE   = 16'h0002,
		ST_ACC    = 16'h0004,
		ST_FIN    = 16'h0008,
		ST_CSTART = 16'h0010,
		ST_CRD    = 16'h0020,
		ST_CWT    = 16'h0040,
		ST_CSQ    = 16'h0080,
		ST_COSQ   = 16'h0100,
		ST_MA     = 16'h0200,
		ST_MB     = 16'h0400,
		ST_MN     = 16'h0800,
		ST_MD1    = 16'h1000,
		ST_MD2    = 16'h2000,
		ST_DIV    = 16'h4000,
		ST_EMIT   = 16'h8000
	} state_t;

	state_t state_q;
	logic [4:0] vars_q;
	logic [5:0] clus_q;
	logic [5:0] step_q;
	logic [VAR_W-1:0] vc_q;
	logic [CNT_W-1:0] sites_q;
	logic [63:0] ss_q;
	logic [47:0] sq_q;
	logic signed [23:0] rank_q;
	logic [31:0] mask_q;
	logic final_q;
	logic signed [SUM_W-1:0] totals_q [MAX_VARS];
	logic [CNT_W-1:0] counts_q [MAX_CLUSTERS];
	logic [CL_W-1:0] c_q;
	logic [VAR_W-1:0] v_q;
	logic [CNT_W-1:0] ns_q;
	logic [NVNS_W-1:0] nvns_q;
	logic [WIDE_W-1:0] a_q;
	logic [WIDE_W-1:0] b_q;
	logic [MAG_W-1:0] smag_q;
	logic [MAG_W-1:0] omag_q;
	logic issued_q;
	logic [ADDR_W-1:0] clr_q;
	out_word_t out_q;

	logic [4:0] nv;
	logic [5:0] nc;
	logic [CL_W-1:0] c_last;
	logic [5:0] step_m1;
	logic [CL_W-1:0] cprev;
	logic [SUM_W-1:0] rank_ext;
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [SUM_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [SUM_W-1:0] mem_rdata;
	logic [CNT_W-1:0] nin;
	logic [CNT_W-1:0] nout;
	logic degen;
	logic signed [SUM_W-1:0] sin;
	logic signed [SUM_W-1:0] sout;
	logic [SUM_W-1:0] sin_abs;
	logic [SUM_W-1:0] sout_abs;
	logic [23:0] in_mag;
	logic [64:0] ss_sum;
	logic [CNT_W-1:0] ns_next;
	logic [17:0] nvns_next;
	logic [4:0] vc_inc;
	mul_req_t mreq;
	logic mul_done;
	logic [WIDE_W-1:0] mul_prod;
	div_req_t dreq;
	logic div_done;
	logic [STAT_W-1:0] div_quot;

	assign nv = nv_eff(vars_q);
	assign nc = nc_eff(clus_q);
	assign c_last = CL_W'(nc - 6'd1);
	assign step_m1 = step_q - 6'd1;
	assign cprev = step_m1[CL_W-1:0];
	assign rank_ext = {{(SUM_W-24){rank_q[23]}}, rank_q};
	assign nin = counts_q[c_q];
	assign nout = ns_q - nin;
	assign degen = (nin == '0) || (nin >= ns_q) || (ss_q == 64'd0);
	assign sin = mem_rdata;
	assign sout = totals_q[v_q] - sin;
	assign sin_abs = sin[SUM_W-1] ? SUM_W'(-sin) : sin;
	assign sout_abs = sout[SUM_W-1] ? SUM_W'(-sout) : sout;
	assign in_mag = in_data.rank_value[23] ? 24'(-in_data.rank_value) : in_data.rank_value;
	assign ss_sum = {1'b0, ss_q} + {17'd0, sq_q};
	assign ns_next = sites_q + {{(CNT_W-1){1'b0}}, (vc_q != '0)};
	assign nvns_next = nv * ns_next;
	assign vc_inc = {1'b0, vc_q} + 5'd1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = {c_q, v_q};
		case (state_q)
			ST_ACC: begin
				mem_raddr = {step_q[CL_W-1:0], vc_q};
				if (step_q != 6'd0 && mask_q[cprev]) begin
					mem_we    = 1'b1;
					mem_waddr = {cprev, vc_q};
					mem_wdata = mem_rdata + rank_ext;
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			ST_CSQ: begin
				mreq.x    = {{(WIDE_W-MAG_W){1'b0}}, smag_q};
				mreq.y    = smag_q;
				mreq.init = a_q;
			end
			ST_COSQ: begin
				mreq.x    = {{(WIDE_W-MAG_W){1'b0}}, omag_q};
				mreq.y    = omag_q;
				mreq.init = b_q;
			end
			ST_MA: begin
				mreq.x = a_q;
				mreq.y = {{(MAG_W-CNT_W){1'b0}}, nout};
			end
			ST_MB: begin
				mreq.x    = b_q;
				mreq.y    = {{(MAG_W-CNT_W){1'b0}}, nin};
				mreq.init = a_q;
			end
			ST_MN: begin
				mreq.x = a_q;
				mreq.y = {{(MAG_W-NVNS_W){1'b0}}, nvns_q};
			end
			ST_MD1: begin
				mreq.x = {{(WIDE_W-CNT_W){1'b0}}, nin};
				mreq.y = {{(MAG_W-CNT_W){1'b0}}, nout};
			end
			ST_MD2: begin
				mreq.x = {{(WIDE_W-64){1'b0}}, ss_q};
				mreq.y = b_q[MAG_W-1:0];
			end
			default: ;
		endcase
		mreq.start = !issued_q && (state_q == ST_CSQ || state_q == ST_COSQ ||
			state_q == ST_MA || state_q == ST_MB || state_q == ST_MN ||
			state_q == ST_MD1 || state_q == ST_MD2);
	end

	always_comb begin
		dreq.start = (state_q == ST_DIV) && !issued_q;
		dreq.num   = {a_q[WIDE_W-17:0], 16'd0};
		dreq.den   = b_q[DEN_W-1:0];
	end

	mrss_sum_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mrss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	mrss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quot   (div_quot)
	);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= 5'd1;
			clus_q <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VARS: vars_q <= cfg_data[4:0];
				CFG_CLUS: clus_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			step_q   <= '0;
			vc_q     <= '0;
			sites_q  <= '0;
			ss_q     <= '0;
			c_q      <= '0;
			v_q      <= '0;
			issued_q <= 1'b0;
			for (int i = 0; i < MAX_VARS; i++)
				totals_q[i] <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++)
				counts_q[i] <= '0;
		end else begin
			if (mreq.start || dreq.start)
				issued_q <= 1'b1;
			case (state_q)
				ST_CLEAR: begin
					for (int i = 0; i < MAX_VARS; i++)
						totals_q[i] <= '0;
					for (int i = 0; i < MAX_CLUSTERS; i++)
						counts_q[i] <= '0;
					ss_q    <= '0;
					sites_q <= '0;
					vc_q    <= '0;
					clr_q   <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						if (sites_q < SITE_LIMIT)
							state_q <= ST_ACC;
						else if (in_data.final_item)
							state_q <= ST_FIN;
					end
				end
				ST_ACC: begin
					step_q <= step_q + 6'd1;
					if (step_q != 6'd0 && mask_q[cprev] && vc_q == '0)
						counts_q[cprev] <= counts_q[cprev] + 1'b1;
					if (step_q == 6'(MAX_CLUSTERS)) begin
						totals_q[vc_q] <= totals_q[vc_q] + rank_ext;
						ss_q <= ss_sum[64] ? {64{1'b1}} : ss_sum[63:0];
						if (vc_inc >= nv) begin
							vc_q    <= '0;
							sites_q <= sites_q + 1'b1;
						end else begin
							vc_q <= vc_inc[VAR_W-1:0];
						end
						state_q <= final_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					c_q     <= '0;
					state_q <= ST_CSTART;
				end
				ST_CSTART: begin
					v_q <= '0;
					if (degen)
						state_q <= ST_EMIT;
					else
						state_q <= ST_CRD;
				end
				ST_CRD: state_q <= ST_CWT;
				ST_CWT: state_q <= ST_CSQ;
				ST_CSQ: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_COSQ;
					end
				end
				ST_COSQ: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						v_q      <= v_q + 1'b1;
						if ({1'b0, v_q} + 5'd1 >= nv)
							state_q <= ST_MA;
						else
							state_q <= ST_CRD;
					end
				end
				ST_MA: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_MB;
					end
				end
				ST_MB: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_MN;
					end
				end
				ST_MN: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_MD1;
					end
				end
				ST_MD1: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_MD2;
					end
				end
				ST_MD2: begin
					if (mul_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						issued_q <= 1'b0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (c_q == c_last) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= ST_CSTART;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// word capture and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rank_q  <= in_data.rank_value;
			mask_q  <= in_data.member_mask;
			final_q <= in_data.final_item;
			sq_q    <= 48'(in_mag * in_mag);
		end
		if (state_q == ST_FIN) begin
			ns_q   <= ns_next;
			nvns_q <= nvns_next[NVNS_W-1:0];
		end
		if (state_q == ST_CSTART) begin
			a_q <= '0;
			b_q <= '0;
			out_q.cluster_index <= c_q;
			out_q.statistic     <= '0;
			out_q.degenerate    <= degen;
			out_q.last_result   <= (c_q == c_last);
		end
		if (state_q == ST_CWT) begin
			smag_q <= sin_abs[MAG_W-1:0];
			omag_q <= sout_abs[MAG_W-1:0];
		end
		if (mul_done) begin
			case (state_q)
				ST_CSQ, ST_MA, ST_MB, ST_MN: a_q <= mul_prod;
				ST_COSQ, ST_MD1, ST_MD2: b_q <= mul_prod;
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_done)
			out_q.statistic <= div_quot;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_data  = out_q;

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a word is pending");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.statistic == '0)
		else $error("degenerate word with nonzero statistic");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_result |-> out_data.cluster_index == c_last)
		else $error("last flag on wrong cluster");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> !in_ready)
		else $error("multiplier finished while idle");

endmodule
